### rtl/luhn_card_brand_check_macros.svh
// Assertion helpers for the checker file.
`ifndef LUHN_CARD_BRAND_CHECK_MACROS_SVH
`define LUHN_CARD_BRAND_CHECK_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define LUHN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define LUHN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/luhn_pkg.sv
package luhn_pkg;

  // Width of the card number input.
  localparam int unsigned IN_W = 63;

  // Binary shift register padded to a whole number of conversion steps.
  localparam int unsigned BITS_PER_STEP = 4;
  localparam int unsigned BIN_W = 64;
  localparam int unsigned CONV_STEPS = BIN_W / BITS_PER_STEP;

  // Largest 63-bit value has 19 decimal digits.
  localparam int unsigned BCD_DIGITS = 19;
  localparam int unsigned BCD_W = 4 * BCD_DIGITS;

  localparam int unsigned DEFAULT_MAX_DIGITS = 19;

  // Card class codes.
  localparam int unsigned CLASS_W = 2;
  typedef enum logic [CLASS_W-1:0] {
    CLASS_INVALID = 2'd0,
    CLASS_NET15   = 2'd1,
    CLASS_NET5X   = 2'd2,
    CLASS_NET4    = 2'd3
  } card_class_e;

  // Number lengths that are recognized.
  localparam int unsigned LEN_13 = 13;
  localparam int unsigned LEN_15 = 15;
  localparam int unsigned LEN_16 = 16;

  // Prefix digits: leading digit and the one after it.
  localparam logic [3:0] PFX15_LEAD      = 4'd3;
  localparam logic [3:0] PFX15_SECOND_A  = 4'd4;
  localparam logic [3:0] PFX15_SECOND_B  = 4'd7;
  localparam logic [3:0] PFX16_LEAD      = 4'd5;
  localparam logic [3:0] PFX16_SECOND_LO = 4'd1;
  localparam logic [3:0] PFX16_SECOND_HI = 4'd5;
  localparam logic [3:0] PFX4_LEAD       = 4'd4;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic conv;
    logic peel;
    logic emit;
  } luhn_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic rest_zero;
    logic cnt_max;
  } luhn_sts_t;

endpackage

### rtl/luhn_card_brand_check.sv
// Channel  Dir  Ports                       Transfer
// command  in   start_i, card_number_i      start_i high while busy_o is low
// result   out  valid_o, card_class_o       valid_o high for one cycle per item
//
// The result strobe rises once the conversion, the peeling of N decimal digits
// (0 up to MAX_DIGITS) and the class decision are through. The conversion steps
// turn the binary number into decimal, four bits per cycle, then one digit is
// peeled per cycle and the class is registered with the strobe; busy_o falls with
// the strobe, so the next item can be accepted while the strobe is shown.
// Reset is asynchronous and active low; it clears the controller and the strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.
module luhn_card_brand_check import luhn_pkg::*; #(
  parameter int unsigned MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [IN_W-1:0]    card_number_i,
  output logic               busy_o,
  output logic [CLASS_W-1:0] card_class_o,
  output logic               valid_o
);

  luhn_cmd_t cmd;
  luhn_sts_t sts;

  // Sequencer for conversion, peeling and result issue.
  luhn_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Conversion, checksum and brand decision.
  luhn_dpath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .card_number_i (card_number_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .card_class_o  (card_class_o),
    .valid_o       (valid_o)
  );

endmodule

### rtl/luhn_ctrl.sv
module luhn_ctrl import luhn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  luhn_sts_t sts_i,
  output luhn_cmd_t cmd_o,
  output logic      busy_o
);

  localparam int unsigned STEP_W = $clog2(CONV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PEEL
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              peel_done;

  // Peeling stops when no digits are left or the digit limit is reached.
  assign peel_done = sts_i.rest_zero || sts_i.cnt_max;

  // Commands decoded from the current state.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_CONV: begin
        cmd_o.conv = 1'b1;
      end
      ST_PEEL: begin
        cmd_o.emit = peel_done;
        cmd_o.peel = !peel_done;
      end
      default: begin
      end
    endcase
  end

  // State, conversion step counter and busy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      busy_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_CONV;
            step_q  <= '0;
            busy_q  <= 1'b1;
          end
        end
        ST_CONV: begin
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(CONV_STEPS - 1)) begin
            state_q <= ST_PEEL;
          end
        end
        ST_PEEL: begin
          if (peel_done) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;

endmodule

### rtl/luhn_dpath.sv
module luhn_dpath import luhn_pkg::*; #(
  parameter int unsigned MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [IN_W-1:0]    card_number_i,
  input  luhn_cmd_t          cmd_i,
  output luhn_sts_t          sts_o,
  output logic [CLASS_W-1:0] card_class_o,
  output logic               valid_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

  // One double-dabble bit: add three to every digit of five or more, then shift in.
  function automatic logic [BCD_W-1:0] dd_bit(input logic [BCD_W-1:0] bcd, input logic b);
    logic [BCD_W-1:0] adj;
    logic [3:0]       dig;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      dig = bcd[4*i +: 4];
      adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  // Digit sum of a doubled digit.
  function automatic logic [3:0] dbl_digit(input logic [3:0] d);
    logic [4:0] dd;
    dd = {d, 1'b0};
    return (dd >= 5'd10) ? 4'(dd - 5'd9) : dd[3:0];
  endfunction

  logic [BIN_W-1:0] bin_q;
  logic [BCD_W-1:0] bcd_q;
  logic [CNT_W-1:0] cnt_q;
  logic [3:0]       sum_q;
  logic [3:0]       lead_q;
  logic [3:0]       second_q;
  card_class_e      class_q;
  logic             valid_q;

  logic [BCD_W-1:0] conv_bcd;
  logic [3:0]       dig;
  logic [3:0]       addend;
  logic [4:0]       sum_raw;
  logic [3:0]       sum_d;
  card_class_e      class_d;

  // Four conversion bits per cycle, most significant binary bit first.
  always_comb begin : conv_logic
    logic [BCD_W-1:0] acc;
    acc = bcd_q;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      acc = dd_bit(acc, bin_q[BIN_W-1-s]);
    end
    conv_bcd = acc;
  end

  // Running Luhn sum kept modulo ten; every second digit from the right is doubled.
  assign dig     = bcd_q[3:0];
  assign addend  = cnt_q[0] ? dbl_digit(dig) : dig;
  assign sum_raw = {1'b0, sum_q} + {1'b0, addend};
  assign sum_d   = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];

  // Brand decision from digit count, checksum and the two leading digits.
  always_comb begin
    class_d = CLASS_INVALID;
    if (sts_o.rest_zero && (cnt_q != '0) && (sum_q == 4'd0)) begin
      if (cnt_q == CNT_W'(LEN_15)) begin
        if ((lead_q == PFX15_LEAD) &&
            ((second_q == PFX15_SECOND_A) || (second_q == PFX15_SECOND_B))) begin
          class_d = CLASS_NET15;
        end
      end else if (cnt_q == CNT_W'(LEN_16)) begin
        if ((lead_q == PFX16_LEAD) && (second_q >= PFX16_SECOND_LO) &&
            (second_q <= PFX16_SECOND_HI)) begin
          class_d = CLASS_NET5X;
        end else if (lead_q == PFX4_LEAD) begin
          class_d = CLASS_NET4;
        end
      end else if ((cnt_q == CNT_W'(LEN_13)) && (lead_q == PFX4_LEAD)) begin
        class_d = CLASS_NET4;
      end
    end
  end

  // Status back to the controller.
  assign sts_o.rest_zero = (bcd_q == '0);
  assign sts_o.cnt_max   = (cnt_q == CNT_W'(MAX_DIGITS));

  // Working registers, steered by the controller commands.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q    <= BIN_W'(card_number_i);
      bcd_q    <= '0;
      cnt_q    <= '0;
      sum_q    <= '0;
      lead_q   <= '0;
      second_q <= '0;
    end else if (cmd_i.conv) begin
      bin_q <= bin_q << BITS_PER_STEP;
      bcd_q <= conv_bcd;
    end else if (cmd_i.peel) begin
      bcd_q    <= bcd_q >> 4;
      cnt_q    <= cnt_q + CNT_W'(1);
      sum_q    <= sum_d;
      second_q <= lead_q;
      lead_q   <= dig;
    end
    if (cmd_i.emit) begin
      class_q <= class_d;
    end
  end

  // Result strobe lasts one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  assign card_class_o = class_q;
  assign valid_o      = valid_q;

endmodule

### rtl/luhn_chk.sv
`include "luhn_card_brand_check_macros.svh"

module luhn_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic valid_o
);

  // An accepted item makes the block busy.
  `LUHN_ASSERT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o |=> busy_o, "busy did not rise after an accepted item")

  // A result is only issued once the block has finished.
  `LUHN_ASSERT(a_valid_idle, clk_i, rst_ni, valid_o |-> !busy_o, "result strobe while busy")

  // Finishing an item always issues its result.
  `LUHN_ASSERT(a_done_result, clk_i, rst_ni, $fell(busy_o) |-> valid_o, "busy fell without a result")

  // One strobe per item: no two results in a row.
  `LUHN_ASSERT(a_single_strobe, clk_i, rst_ni, valid_o |=> !valid_o, "result strobe held for two cycles")

  // Reset holds the strobe low.
  `LUHN_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !valid_o && !busy_o, "outputs active in reset")

endmodule

bind luhn_card_brand_check luhn_chk u_luhn_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .valid_o (valid_o)
);
